>>> src/ccfd_pkg.sv
// Package for the CRC-checked frame deframer.
// Holds sizes, register indexes and the CRC-16/MODBUS byte step; no dependencies.
package ccfd_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int HEADER_BYTES    = 6;
  localparam int MIN_FRAME_BYTES = HEADER_BYTES + 2;
  localparam int MAX_ITEMS       = 56;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int FILL_W          = ADDR_W + 1;
  localparam int ITEM_W          = $clog2(MAX_ITEMS + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic [1:0] REG_FIRST_MAGIC  = 2'd0;
  localparam logic [1:0] REG_SECOND_MAGIC = 2'd1;
  localparam logic [1:0] REG_VERSION      = 2'd2;

  // input kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // result kinds
  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_EMPTY   = 1'b1;

  // fold one byte into a reflected CRC-16/MODBUS value
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/ccfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/crc_checked_frame_deframer_core.sv
// CRC-checked frame deframer: one byte beat in, a sequencer over a circular
// byte store hunts, checks and emits. It hunts for the magic bytes, reads the
// header and CRC fields, runs the CRC over len-2 bytes and reads the type, then
// emits one result beat per cycle while out_ready holds; a rejection rescans the store.
// Throughput: one input beat per pass of the sequencer; a parse reset beat
// resets the store's head and fill without starting a pass.
// Reset (rst_n low, synchronous) clears the parse, the counters and restores
// register defaults; the store is not cleared.
module crc_checked_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_frame_type,
  output logic [7:0]  out_hdr_version,
  output logic [6:0]  out_frame_length,
  output logic [15:0] out_frame_crc,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_payload_index,
  output logic        out_last,
  output logic [31:0] out_good_frames,
  output logic [31:0] out_crc_failures,
  output logic [31:0] out_length_rejects,
  output logic [31:0] out_version_rejects
);

  import ccfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HUNT, S_HUNT_W, S_M1, S_M1_W, S_VER_W, S_LH_W, S_LL_W,
    S_CH_W, S_CL_W, S_CRC_W, S_TYP_W, S_EMIT, S_EMIT_W
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]        m0_r, m0_nxt, m1_r, m1_nxt, ver_cfg_r, ver_cfg_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt, rd_addr_r, rd_addr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, p_r, p_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [6:0]        len_r, len_nxt;
  logic              lenhi_r, lenhi_nxt;
  logic [15:0]       crc_r, crc_nxt, rxcrc_r, rxcrc_nxt;
  logic [7:0]        ver_r, ver_nxt, typ_r, typ_nxt;
  logic [ITEM_W-1:0] items_r, items_nxt;
  logic [31:0]       good_r, good_nxt, cfail_r, cfail_nxt;
  logic [31:0]       lfail_r, lfail_nxt, vfail_r, vfail_nxt;
  logic              ov_r, ov_nxt, ok_r, ok_nxt, olast_r, olast_nxt;
  logic [7:0]        opb_r, opb_nxt;
  logic [5:0]        opi_r, opi_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        rdata;
  logic              out_free;
  logic [15:0]       crc_step;
  logic [ADDR_W-1:0] plen;

  ccfd_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte),
    .rd_addr (rd_addr_nxt),
    .rd_data (rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !ov_r || out_ready;
  assign crc_step = crc_byte(crc_r, rdata);
  assign plen     = ADDR_W'(len_r - 7'(MIN_FRAME_BYTES));
  assign wr_en    = in_valid && in_ready && (in_kind == KIND_BYTE);
  assign wr_addr  = head_r + fill_r[ADDR_W-1:0];

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    m0_nxt      = m0_r;
    m1_nxt      = m1_r;
    ver_cfg_nxt = ver_cfg_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    p_nxt       = p_r;
    idx_nxt     = idx_r;
    len_nxt     = len_r;
    lenhi_nxt   = lenhi_r;
    crc_nxt     = crc_r;
    rxcrc_nxt   = rxcrc_r;
    ver_nxt     = ver_r;
    typ_nxt     = typ_r;
    items_nxt   = items_r;
    good_nxt    = good_r;
    cfail_nxt   = cfail_r;
    lfail_nxt   = lfail_r;
    vfail_nxt   = vfail_r;
    rd_addr_nxt = rd_addr_r;
    ov_nxt      = ov_r && !out_ready;
    ok_nxt      = ok_r;
    olast_nxt   = olast_r;
    opb_nxt     = opb_r;
    opi_nxt     = opi_r;

    // register writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIRST_MAGIC:  m0_nxt      = cfg_data;
        REG_SECOND_MAGIC: m1_nxt      = cfg_data;
        REG_VERSION:      ver_cfg_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_RESET) begin
            fill_nxt = '0;
            head_nxt = '0;
          end else begin
            // store is never full here; guard drops the oldest byte
            if (fill_r == FILL_W'(MAX_FRAME_BYTES)) begin
              head_nxt = head_r + ADDR_W'(1);
            end else begin
              fill_nxt = fill_r + FILL_W'(1);
            end
            p_nxt     = '0;
            items_nxt = '0;
            state_nxt = S_HUNT;
          end
        end
      end
      S_HUNT: begin
        if (p_r < fill_r) begin
          rd_addr_nxt = head_r + p_r[ADDR_W-1:0];
          state_nxt   = S_HUNT_W;
        end else begin
          head_nxt  = head_r + p_r[ADDR_W-1:0];
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_HUNT_W: begin
        if (rdata == m0_r) begin
          head_nxt  = head_r + p_r[ADDR_W-1:0];
          fill_nxt  = fill_r - p_r;
          state_nxt = S_M1;
        end else begin
          p_nxt     = p_r + FILL_W'(1);
          state_nxt = S_HUNT;
        end
      end
      S_M1: begin
        if (fill_r < FILL_W'(2)) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr_nxt = head_r + ADDR_W'(1);
          state_nxt   = S_M1_W;
        end
      end
      S_M1_W: begin
        if (rdata != m1_r) begin
          head_nxt  = head_r + ADDR_W'(1);
          fill_nxt  = fill_r - FILL_W'(1);
          p_nxt     = '0;
          state_nxt = S_HUNT;
        end else if (fill_r < FILL_W'(3)) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr_nxt = head_r + ADDR_W'(2);
          state_nxt   = S_VER_W;
        end
      end
      S_VER_W: begin
        if (rdata != ver_cfg_r) begin
          vfail_nxt = vfail_r + 32'd1;
          head_nxt  = head_r + ADDR_W'(1);
          fill_nxt  = fill_r - FILL_W'(1);
          p_nxt     = '0;
          state_nxt = S_HUNT;
        end else if (fill_r < FILL_W'(5)) begin
          state_nxt = S_IDLE;
        end else begin
          ver_nxt     = rdata;
          rd_addr_nxt = head_r + ADDR_W'(3);
          state_nxt   = S_LH_W;
        end
      end
      S_LH_W: begin
        lenhi_nxt   = (rdata != 8'd0);
        rd_addr_nxt = head_r + ADDR_W'(4);
        state_nxt   = S_LL_W;
      end
      S_LL_W: begin
        if (lenhi_r || rdata < 8'(MIN_FRAME_BYTES) || rdata > 8'(MAX_FRAME_BYTES)) begin
          lfail_nxt = lfail_r + 32'd1;
          head_nxt  = head_r + ADDR_W'(1);
          fill_nxt  = fill_r - FILL_W'(1);
          p_nxt     = '0;
          state_nxt = S_HUNT;
        end else if (fill_r < rdata[FILL_W-1:0]) begin
          state_nxt = S_IDLE;
        end else begin
          len_nxt     = rdata[6:0];
          rd_addr_nxt = head_r + ADDR_W'(rdata[6:0] - 7'd2);
          state_nxt   = S_CH_W;
        end
      end
      S_CH_W: begin
        rxcrc_nxt[15:8] = rdata;
        rd_addr_nxt     = head_r + ADDR_W'(len_r - 7'd1);
        state_nxt       = S_CL_W;
      end
      S_CL_W: begin
        rxcrc_nxt[7:0] = rdata;
        crc_nxt        = CRC_INIT;
        idx_nxt        = '0;
        rd_addr_nxt    = head_r;
        state_nxt      = S_CRC_W;
      end
      S_CRC_W: begin
        // one byte of CRC per visit
        if (7'(idx_r) + 7'd1 == len_r - 7'd2) begin
          if (crc_step != rxcrc_r) begin
            cfail_nxt = cfail_r + 32'd1;
            head_nxt  = head_r + ADDR_W'(1);
            fill_nxt  = fill_r - FILL_W'(1);
            p_nxt     = '0;
            state_nxt = S_HUNT;
          end else begin
            good_nxt    = good_r + 32'd1;
            rd_addr_nxt = head_r + ADDR_W'(5);
            state_nxt   = S_TYP_W;
          end
        end else begin
          crc_nxt     = crc_step;
          idx_nxt     = idx_r + ADDR_W'(1);
          rd_addr_nxt = head_r + idx_r + ADDR_W'(1);
        end
      end
      S_TYP_W: begin
        typ_nxt = rdata;
        idx_nxt = '0;
        if (len_r == 7'(MIN_FRAME_BYTES)) begin
          state_nxt = S_EMIT;
        end else begin
          rd_addr_nxt = head_r + ADDR_W'(HEADER_BYTES);
          state_nxt   = S_EMIT_W;
        end
      end
      S_EMIT: begin
        // empty frame: one item, unless the beat's item budget is spent
        if (items_r == ITEM_W'(MAX_ITEMS) || out_free) begin
          if (items_r != ITEM_W'(MAX_ITEMS)) begin
            ov_nxt    = 1'b1;
            ok_nxt    = ITEM_EMPTY;
            opb_nxt   = 8'd0;
            opi_nxt   = '0;
            olast_nxt = 1'b1;
            items_nxt = items_r + ITEM_W'(1);
          end
          head_nxt  = head_r + len_r[ADDR_W-1:0];
          fill_nxt  = fill_r - FILL_W'(len_r);
          p_nxt     = '0;
          state_nxt = S_HUNT;
        end
      end
      S_EMIT_W: begin
        if (items_r == ITEM_W'(MAX_ITEMS) || out_free) begin
          if (items_r != ITEM_W'(MAX_ITEMS)) begin
            ov_nxt    = 1'b1;
            ok_nxt    = ITEM_PAYLOAD;
            opb_nxt   = rdata;
            opi_nxt   = 6'(idx_r);
            olast_nxt = (idx_r + ADDR_W'(1) == plen);
            items_nxt = items_r + ITEM_W'(1);
          end
          if (idx_r + ADDR_W'(1) == plen) begin
            head_nxt  = head_r + len_r[ADDR_W-1:0];
            fill_nxt  = fill_r - FILL_W'(len_r);
            p_nxt     = '0;
            state_nxt = S_HUNT;
          end else begin
            idx_nxt     = idx_r + ADDR_W'(1);
            rd_addr_nxt = head_r + ADDR_W'(HEADER_BYTES) + idx_r + ADDR_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      m0_r      <= 8'hEB;
      m1_r      <= 8'h90;
      ver_cfg_r <= 8'h01;
      head_r    <= '0;
      fill_r    <= '0;
      p_r       <= '0;
      items_r   <= '0;
      good_r    <= '0;
      cfail_r   <= '0;
      lfail_r   <= '0;
      vfail_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      m0_r      <= m0_nxt;
      m1_r      <= m1_nxt;
      ver_cfg_r <= ver_cfg_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      p_r       <= p_nxt;
      items_r   <= items_nxt;
      good_r    <= good_nxt;
      cfail_r   <= cfail_nxt;
      lfail_r   <= lfail_nxt;
      vfail_r   <= vfail_nxt;
      ov_r      <= ov_nxt;
    end
    rd_addr_r <= rd_addr_nxt;
    idx_r     <= idx_nxt;
    len_r     <= len_nxt;
    lenhi_r   <= lenhi_nxt;
    crc_r     <= crc_nxt;
    rxcrc_r   <= rxcrc_nxt;
    ver_r     <= ver_nxt;
    typ_r     <= typ_nxt;
    ok_r      <= ok_nxt;
    olast_r   <= olast_nxt;
    opb_r     <= opb_nxt;
    opi_r     <= opi_nxt;
    // snapshot frame fields and counters with each loaded item
    if (ov_nxt && !(ov_r && !out_ready)) begin
      out_frame_type      <= typ_nxt;
      out_hdr_version     <= ver_r;
      out_frame_length    <= len_r;
      out_frame_crc       <= rxcrc_r;
      out_good_frames     <= good_r;
      out_crc_failures    <= cfail_r;
      out_length_rejects  <= lfail_r;
      out_version_rejects <= vfail_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_item_kind     = ok_r;
  assign out_payload_byte  = opb_r;
  assign out_payload_index = opi_r;
  assign out_last          = olast_r;

endmodule

>>> src/ccfd_checker.sv
// Port-level checker for the CRC-checked frame deframer, with its bind.
// Depends on crc_checked_frame_deframer_core.
module ccfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_item_kind,
  input logic [6:0]  out_frame_length,
  input logic [7:0]  out_payload_byte,
  input logic [5:0]  out_payload_index,
  input logic        out_last
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_last))
    else $error("stalled result beat changed");

  // a byte beat starts a pass; no beat is taken in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind |=> !in_ready)
    else $error("input taken during a pass");

  // an empty-frame item is the whole frame
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind |-> out_last && out_payload_byte == 8'd0
      && out_payload_index == 6'd0)
    else $error("malformed empty-frame item");

  // emitted lengths are within the accepted range
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_length >= 7'd8 && out_frame_length <= 7'd64)
    else $error("emitted length out of range");

  // payload index does not exceed the payload length
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind |-> 7'(out_payload_index) + 7'd8 < out_frame_length + 7'd1)
    else $error("payload index beyond frame");

endmodule

bind crc_checked_frame_deframer_core ccfd_checker u_ccfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_kind           (in_kind),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_item_kind     (out_item_kind),
  .out_frame_length  (out_frame_length),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_last          (out_last)
);
